// File: design/nfdt_pkg.sv
package nfdt_pkg;

   localparam int NUM_DESCRIPTORS_DEF = 32;
   localparam int NUM_QUEUES_DEF      = 16;
   localparam int QUEUE_DEPTH_DEF     = 1024;
   localparam int BYTES_PER_ITEM_DEF  = 8;

   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_OPEN   = 3'd1;
   localparam logic [2:0] REQ_DUP    = 3'd2;
   localparam logic [2:0] REQ_CLOSE  = 3'd3;
   localparam logic [2:0] REQ_WRITE  = 3'd4;
   localparam logic [2:0] REQ_READ   = 3'd5;

   localparam logic [1:0] MODE_RW = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  fifo_id;
      logic [1:0]  access_mode;
      logic [4:0]  descriptor;
      logic [3:0]  byte_count;
      logic [63:0] data_word;
   } nfdt_req_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  new_descriptor;
      logic [3:0]  moved_count;
      logic [63:0] data_out;
   } nfdt_rsp_type;

   // Command from the controller to every byte lane.
   typedef struct packed {
      logic       go;
      logic       wr;
      logic [3:0] moved;
   } nfdt_lane_cmd_type;

endpackage

// File: design/nfdt_ram.sv
module nfdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (wr_en) begin
            mem[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem[addr];
         end
      end
   end

endmodule

// File: design/nfdt_lane.sv
module nfdt_lane #(
   parameter int LANE        = 0,
   parameter int NUM_LANES   = 8,
   parameter int QUEUE_DEPTH = 1024,
   parameter int QIW         = 4
) (
   input  logic                           clock,
   input  nfdt_pkg::nfdt_lane_cmd_type    cmd,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] start_pos,
   input  logic [QIW-1:0]                 queue,
   input  logic [63:0]                    wr_word,
   output logic [7:0]                     rd_byte
);

   localparam int HW   = $clog2(QUEUE_DEPTH);
   localparam int LG   = $clog2(NUM_LANES);
   localparam int LIW  = (LG > 0) ? LG : 1;
   localparam int ROWS = (QUEUE_DEPTH + NUM_LANES - 1) / NUM_LANES;
   localparam int RW   = $clog2(ROWS);
   localparam int AW   = QIW + RW;

   logic [LIW-1:0] offset;
   logic [HW:0]    pos_sum;
   logic [HW-1:0]  pos;
   logic [RW-1:0]  row;
   logic           hit;
   logic [7:0]     wr_byte;

   // Byte of the transfer that falls into this lane.
   generate
      if (LG > 0) begin : g_multi
         assign offset = LIW'(LANE) - start_pos[LIW-1:0];
      end else begin : g_single
         assign offset = start_pos[0] & 1'b0;
      end
   endgenerate

   always_comb begin
      pos_sum = {1'b0, start_pos} + (HW+1)'(offset);
      if (pos_sum >= (HW+1)'(QUEUE_DEPTH)) begin
         pos_sum = pos_sum - (HW+1)'(QUEUE_DEPTH);
      end
      pos     = pos_sum[HW-1:0];
      row     = RW'(pos >> LG);
      hit     = cmd.go && (4'(offset) < cmd.moved);
      wr_byte = wr_word[{3'(offset), 3'b000} +: 8];
   end

   nfdt_ram #(
      .WIDTH (8),
      .DEPTH ((2 ** QIW) * (2 ** RW))
   ) u_ram (
      .clock      (clock),
      .en         (hit),
      .wr_en      (cmd.wr),
      .addr       (AW'({queue, row})),
      .wr_data    (wr_byte),
      .rd_data_ff (rd_byte)
   );

endmodule

// File: design/named_fifo_descriptor_table.sv
// Table of byte FIFO rings reached through descriptors.
// Requests come in on the req_ channel (valid/ready) as one word: create a
// FIFO, open, dup or close a descriptor, or write or read up to
// BYTES_PER_ITEM bytes. Every request gives exactly one response word on the
// rsp_ channel, in request order.
// A request is taken into a register while the block is idle and executed
// in the execute state; writes and control requests finish there, reads
// pass through a data state for the byte lane memories to return their
// registered data. A new request is taken only once the previous one is
// done and the block is idle again, so the block cannot take a new request
// while one is still in progress.
// The response sits in an output register; while the receiver stalls the
// next request is still taken and executed up to the point where its
// response would overwrite the one waiting.
// Reset clears all FIFOs and descriptors at once; ring contents are not
// cleared and only bytes that were written are ever read back.
module named_fifo_descriptor_table #(
   parameter int NUM_DESCRIPTORS = nfdt_pkg::NUM_DESCRIPTORS_DEF,
   parameter int NUM_QUEUES      = nfdt_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH     = nfdt_pkg::QUEUE_DEPTH_DEF,
   parameter int BYTES_PER_ITEM  = nfdt_pkg::BYTES_PER_ITEM_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nfdt_pkg::nfdt_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nfdt_pkg::nfdt_rsp_type rsp_data
);

   localparam int DIW   = $clog2(NUM_DESCRIPTORS);
   localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int HW    = $clog2(QUEUE_DEPTH);
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam int RCW   = $clog2(NUM_DESCRIPTORS + 1);
   localparam int LG    = $clog2(BYTES_PER_ITEM);
   localparam int LANES = 2 ** LG;
   localparam int LIW   = (LG > 0) ? LG : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDATA
   } state_type;

   state_type              state_ff;
   nfdt_pkg::nfdt_req_type req_ff;
   nfdt_pkg::nfdt_rsp_type rsp_ff;
   logic                   rsp_valid_ff;
   logic [HW-1:0]          rd_pos_ff;
   logic [3:0]             rd_moved_ff;
   logic                   rd_status_ff;

   logic             fifo_valid_ff [NUM_QUEUES];
   logic [1:0]       fifo_mask_ff  [NUM_QUEUES];
   logic [HW-1:0]    head_ptr_ff   [NUM_QUEUES];
   logic [FW-1:0]    fill_level_ff [NUM_QUEUES];
   logic [RCW-1:0]   ref_count_ff  [NUM_QUEUES];
   logic             desc_valid_ff [NUM_DESCRIPTORS];
   logic [1:0]       desc_mode_ff  [NUM_DESCRIPTORS];
   logic [QIW-1:0]   desc_target_ff[NUM_DESCRIPTORS];

   logic [3:0]       cnt;
   logic [DIW-1:0]   dix;
   logic             d_ok;
   logic [QIW-1:0]   qid;
   logic             id_ok;
   logic [QIW-1:0]   qsel;
   logic [1:0]       open_mode;
   logic [DIW-1:0]   free_ix;
   logic             free_found;
   logic [FW-1:0]    space;
   logic [HW:0]      wsum;
   logic [HW-1:0]    wr_pos;
   logic [HW:0]      hsum;
   logic [RCW-1:0]   ref_dec;
   logic             out_free;
   logic             advance;
   logic             rsp_load;

   // Per-request effects.
   logic             status_in;
   logic [4:0]       newd_in;
   logic [3:0]       moved_in;
   logic             queue_create;
   logic             queue_clear;
   logic             ref_inc;
   logic             ref_set;
   logic             desc_new;
   logic             desc_free;
   logic             xfer_wr;
   logic             xfer_rd;
   logic [1:0]       new_mode;

   nfdt_pkg::nfdt_lane_cmd_type lane_cmd;
   logic [HW-1:0]    lane_pos;
   logic [7:0]       lane_byte [LANES];
   logic [63:0]      merged;

   always_comb begin
      cnt = (req_ff.byte_count > 4'(BYTES_PER_ITEM)) ? 4'(BYTES_PER_ITEM)
                                                    : req_ff.byte_count;
      dix   = DIW'(req_ff.descriptor);
      d_ok  = (32'(req_ff.descriptor) < 32'(NUM_DESCRIPTORS)) && desc_valid_ff[dix];
      qid   = QIW'(req_ff.fifo_id);
      id_ok = 32'(req_ff.fifo_id) < 32'(NUM_QUEUES);
      qsel  = (req_ff.req_type == nfdt_pkg::REQ_CREATE ||
               req_ff.req_type == nfdt_pkg::REQ_OPEN) ? qid : desc_target_ff[dix];
      open_mode = (req_ff.access_mode == 2'd0) ? nfdt_pkg::MODE_RW : req_ff.access_mode;

      free_ix    = '0;
      free_found = 1'b0;
      for (int i = NUM_DESCRIPTORS - 1; i >= 0; i--) begin
         if (!desc_valid_ff[i]) begin
            free_ix    = DIW'(i);
            free_found = 1'b1;
         end
      end

      space = FW'(QUEUE_DEPTH) - fill_level_ff[qsel];
      wsum  = (HW+1)'(head_ptr_ff[qsel]) + (HW+1)'(fill_level_ff[qsel]);
      if (wsum >= (HW+1)'(QUEUE_DEPTH)) begin
         wsum = wsum - (HW+1)'(QUEUE_DEPTH);
      end
      wr_pos  = wsum[HW-1:0];
      ref_dec = (ref_count_ff[qsel] != '0) ? ref_count_ff[qsel] - 1'b1 : '0;

      status_in    = 1'b1;
      newd_in      = '0;
      moved_in     = '0;
      queue_create = 1'b0;
      queue_clear  = 1'b0;
      ref_inc      = 1'b0;
      ref_set      = 1'b0;
      desc_new     = 1'b0;
      desc_free    = 1'b0;
      xfer_wr      = 1'b0;
      xfer_rd      = 1'b0;
      new_mode     = open_mode;

      case (req_ff.req_type)
         nfdt_pkg::REQ_CREATE: begin
            if (id_ok && !fifo_valid_ff[qsel]) begin
               status_in    = 1'b0;
               queue_create = 1'b1;
            end
         end
         nfdt_pkg::REQ_OPEN: begin
            if (free_found && id_ok && fifo_valid_ff[qsel] &&
                ((open_mode & fifo_mask_ff[qsel]) == open_mode)) begin
               status_in = 1'b0;
               desc_new  = 1'b1;
               ref_inc   = 1'b1;
               newd_in   = 5'(free_ix);
            end
         end
         nfdt_pkg::REQ_DUP: begin
            if (d_ok && free_found) begin
               status_in = 1'b0;
               desc_new  = 1'b1;
               ref_inc   = 1'b1;
               new_mode  = desc_mode_ff[dix];
               newd_in   = 5'(free_ix);
            end
         end
         nfdt_pkg::REQ_CLOSE: begin
            if (d_ok) begin
               status_in   = 1'b0;
               desc_free   = 1'b1;
               queue_clear = (ref_dec == '0);
               ref_set     = 1'b1;
            end
         end
         nfdt_pkg::REQ_WRITE: begin
            if (d_ok && desc_mode_ff[dix][1]) begin
               status_in = 1'b0;
               xfer_wr   = 1'b1;
               moved_in  = (FW'(cnt) < space) ? cnt : 4'(space);
            end
         end
         nfdt_pkg::REQ_READ: begin
            if (d_ok && desc_mode_ff[dix][0]) begin
               status_in = 1'b0;
               xfer_rd   = 1'b1;
               moved_in  = (FW'(cnt) < fill_level_ff[qsel]) ? cnt
                                                             : 4'(fill_level_ff[qsel]);
            end
         end
         default: begin
         end
      endcase

      hsum = (HW+1)'(head_ptr_ff[qsel]) + (HW+1)'(moved_in);
      if (hsum >= (HW+1)'(QUEUE_DEPTH)) begin
         hsum = hsum - (HW+1)'(QUEUE_DEPTH);
      end

      out_free = !rsp_valid_ff || rsp_ready;
      advance  = (state_ff == ST_EXEC) &&
                 (out_free || req_ff.req_type == nfdt_pkg::REQ_READ);
      // A new response word is loaded either straight from the execute stage
      // or, for a read, once the lane data has arrived.
      rsp_load = (advance && req_ff.req_type != nfdt_pkg::REQ_READ) ||
                 (state_ff == ST_RDATA && out_free);

      lane_cmd.go    = advance && (xfer_wr || xfer_rd);
      lane_cmd.wr    = xfer_wr;
      lane_cmd.moved = moved_in;
      lane_pos       = xfer_wr ? wr_pos : head_ptr_ff[qsel];
   end

   generate
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         nfdt_lane #(
            .LANE        (l),
            .NUM_LANES   (LANES),
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .QIW         (QIW)
         ) u_lane (
            .clock     (clock),
            .cmd       (lane_cmd),
            .start_pos (lane_pos),
            .queue     (qsel),
            .wr_word   (req_ff.data_word),
            .rd_byte   (lane_byte[l])
         );
      end
   endgenerate

   // Merge the lane outputs back into request byte order.
   always_comb begin
      logic [LIW-1:0] sel;
      merged = '0;
      for (int k = 0; k < BYTES_PER_ITEM; k++) begin
         sel = LIW'(rd_pos_ff) + LIW'(k);
         if (LG == 0) begin
            sel = '0;
         end
         if (4'(k) < rd_moved_ff) begin
            merged[8*k +: 8] = lane_byte[sel];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            fifo_valid_ff[q] <= 1'b0;
            fifo_mask_ff[q]  <= '0;
            head_ptr_ff[q]   <= '0;
            fill_level_ff[q] <= '0;
            ref_count_ff[q]  <= '0;
         end
         for (int d = 0; d < NUM_DESCRIPTORS; d++) begin
            desc_valid_ff[d]  <= 1'b0;
            desc_mode_ff[d]   <= '0;
            desc_target_ff[d] <= '0;
         end
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (advance) begin
                  if (queue_create) begin
                     fifo_valid_ff[qsel] <= 1'b1;
                     fifo_mask_ff[qsel]  <= req_ff.access_mode;
                     head_ptr_ff[qsel]   <= '0;
                     fill_level_ff[qsel] <= '0;
                     ref_count_ff[qsel]  <= '0;
                  end
                  if (queue_clear) begin
                     fifo_valid_ff[qsel] <= 1'b0;
                     fifo_mask_ff[qsel]  <= '0;
                     head_ptr_ff[qsel]   <= '0;
                     fill_level_ff[qsel] <= '0;
                  end
                  if (ref_inc) begin
                     ref_count_ff[qsel] <= ref_count_ff[qsel] + 1'b1;
                  end
                  if (ref_set) begin
                     ref_count_ff[qsel] <= ref_dec;
                  end
                  if (desc_new) begin
                     desc_valid_ff[free_ix]  <= 1'b1;
                     desc_mode_ff[free_ix]   <= new_mode;
                     desc_target_ff[free_ix] <= qsel;
                  end
                  if (desc_free) begin
                     desc_valid_ff[dix]  <= 1'b0;
                     desc_mode_ff[dix]   <= '0;
                     desc_target_ff[dix] <= '0;
                  end
                  if (xfer_wr) begin
                     fill_level_ff[qsel] <= fill_level_ff[qsel] + FW'(moved_in);
                  end
                  if (xfer_rd) begin
                     head_ptr_ff[qsel]   <= hsum[HW-1:0];
                     fill_level_ff[qsel] <= fill_level_ff[qsel] - FW'(moved_in);
                  end
                  // A read may run ahead of a stalled response word, so its
                  // status is parked until the data phase.
                  if (req_ff.req_type == nfdt_pkg::REQ_READ) begin
                     rd_pos_ff    <= head_ptr_ff[qsel];
                     rd_moved_ff  <= moved_in;
                     rd_status_ff <= status_in;
                     state_ff     <= ST_RDATA;
                  end else begin
                     rsp_ff.status         <= status_in;
                     rsp_ff.new_descriptor <= newd_in;
                     rsp_ff.moved_count    <= moved_in;
                     rsp_ff.data_out       <= '0;
                     state_ff              <= ST_IDLE;
                  end
               end
            end
            ST_RDATA: begin
               if (out_free) begin
                  rsp_ff.status         <= rd_status_ff;
                  rsp_ff.new_descriptor <= '0;
                  rsp_ff.moved_count    <= rd_moved_ff;
                  rsp_ff.data_out       <= merged;
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sim/nfdt_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow of the descriptor table and the rings,
// and compares every response word with the oldest predicted one.
module nfdt_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  nfdt_pkg::nfdt_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  nfdt_pkg::nfdt_rsp_type rsp_data,
   output int                     error_count,
   output int                     pending_count
);

   localparam int NDESC  = nfdt_pkg::NUM_DESCRIPTORS_DEF;
   localparam int NQUEUE = nfdt_pkg::NUM_QUEUES_DEF;
   localparam int DEPTH  = nfdt_pkg::QUEUE_DEPTH_DEF;
   localparam int LANES  = nfdt_pkg::BYTES_PER_ITEM_DEF;

   logic [7:0]  ring_bytes [NQUEUE][DEPTH];
   logic        queue_live [NQUEUE];
   logic [1:0]  queue_mask [NQUEUE];
   logic [9:0]  queue_head [NQUEUE];
   logic [10:0] queue_fill [NQUEUE];
   logic [5:0]  queue_refs [NQUEUE];
   logic        desc_live [NDESC];
   logic [1:0]  desc_rights [NDESC];
   logic [3:0]  desc_queue [NDESC];

   nfdt_pkg::nfdt_rsp_type expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic int lowest_free_slot();
      for (int i = 0; i < NDESC; i++)
         if (!desc_live[i]) return i;
      return -1;
   endfunction

   function automatic void drop_queue(int q);
      queue_live[q] = 1'b0;
      queue_mask[q] = '0;
      queue_head[q] = '0;
      queue_fill[q] = '0;
      queue_refs[q] = '0;
   endfunction

   function automatic nfdt_pkg::nfdt_rsp_type apply_request(nfdt_pkg::nfdt_req_type r);
      nfdt_pkg::nfdt_rsp_type res;
      int nd, q, cnt, moved;
      logic [1:0] mode;
      res = '0;
      res.status = 1'b1;
      cnt = (r.byte_count > LANES) ? LANES : r.byte_count;
      mode = r.access_mode;
      case (r.req_type)
         nfdt_pkg::REQ_CREATE: begin
            if (!queue_live[r.fifo_id]) begin
               drop_queue(r.fifo_id);
               queue_live[r.fifo_id] = 1'b1;
               queue_mask[r.fifo_id] = mode;
               res.status = 1'b0;
            end
         end
         nfdt_pkg::REQ_OPEN: begin
            if (mode == 2'd0) mode = nfdt_pkg::MODE_RW;
            nd = lowest_free_slot();
            if (nd >= 0 && queue_live[r.fifo_id] &&
                (mode & queue_mask[r.fifo_id]) == mode) begin
               desc_live[nd] = 1'b1;
               desc_rights[nd] = mode;
               desc_queue[nd] = r.fifo_id;
               queue_refs[r.fifo_id]++;
               res.new_descriptor = 5'(nd);
               res.status = 1'b0;
            end
         end
         nfdt_pkg::REQ_DUP: begin
            nd = lowest_free_slot();
            if (desc_live[r.descriptor] && nd >= 0) begin
               desc_live[nd] = 1'b1;
               desc_rights[nd] = desc_rights[r.descriptor];
               desc_queue[nd] = desc_queue[r.descriptor];
               queue_refs[desc_queue[r.descriptor]]++;
               res.new_descriptor = 5'(nd);
               res.status = 1'b0;
            end
         end
         nfdt_pkg::REQ_CLOSE: begin
            if (desc_live[r.descriptor]) begin
               q = desc_queue[r.descriptor];
               if (queue_refs[q] > 0) queue_refs[q]--;
               if (queue_refs[q] == 0) drop_queue(q);
               desc_live[r.descriptor] = 1'b0;
               desc_rights[r.descriptor] = '0;
               desc_queue[r.descriptor] = '0;
               res.status = 1'b0;
            end
         end
         nfdt_pkg::REQ_WRITE: begin
            if (desc_live[r.descriptor] && desc_rights[r.descriptor][1]) begin
               q = desc_queue[r.descriptor];
               moved = (cnt < DEPTH - queue_fill[q]) ? cnt : DEPTH - queue_fill[q];
               for (int i = 0; i < moved; i++)
                  ring_bytes[q][(queue_head[q] + queue_fill[q] + i) % DEPTH] =
                     r.data_word[8*i +: 8];
               queue_fill[q] = queue_fill[q] + 11'(moved);
               res.moved_count = 4'(moved);
               res.status = 1'b0;
            end
         end
         nfdt_pkg::REQ_READ: begin
            if (desc_live[r.descriptor] && desc_rights[r.descriptor][0]) begin
               q = desc_queue[r.descriptor];
               moved = (cnt < queue_fill[q]) ? cnt : queue_fill[q];
               for (int i = 0; i < moved; i++)
                  res.data_out[8*i +: 8] = ring_bytes[q][(queue_head[q] + i) % DEPTH];
               queue_head[q] = 10'((queue_head[q] + moved) % DEPTH);
               queue_fill[q] = queue_fill[q] - 11'(moved);
               res.moved_count = 4'(moved);
               res.status = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      nfdt_pkg::nfdt_rsp_type exp_rsp;
      if (reset) begin
         for (int q = 0; q < NQUEUE; q++) drop_queue(q);
         for (int d = 0; d < NDESC; d++) begin
            desc_live[d] = 1'b0;
            desc_rights[d] = '0;
            desc_queue[d] = '0;
         end
         expected_rsps.delete();
         error_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("%0t: response word with none expected: %p", $realtime, rsp_data);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data !== exp_rsp) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("%0t: mismatch: expected %p, got %p",
                              $realtime, exp_rsp, rsp_data);
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsps.push_back(apply_request(req_data));
      end
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_ready;
   nfdt_pkg::nfdt_req_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 0;
   nfdt_pkg::nfdt_rsp_type rsp_data;
   int                     error_count;
   int                     pending_count;
   int                     hold_cycles = 0;

   // Descriptors that this side believes are open, to aim requests well.
   int open_descs[$];

   always #5 clock = ~clock;

   named_fifo_descriptor_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   nfdt_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   // Receiver: random stalls, plus one long hold-off started by the sender side.
   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         if (hold_cycles > 0) begin
            rsp_ready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         rsp_ready <= (gap == 0);
         @(posedge clock);
         if (gap > 1) repeat (gap - 1) @(posedge clock);
      end
   end

   task automatic send_word(nfdt_pkg::nfdt_req_type w);
      int gap;
      req_data <= w;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gap = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic nfdt_pkg::nfdt_req_type make_req(logic [2:0] kind, int id, int mode,
                                                       int desc, int cnt,
                                                       logic [63:0] data);
      nfdt_pkg::nfdt_req_type w;
      w.req_type = kind;
      w.fifo_id = 4'(id);
      w.access_mode = 2'(mode);
      w.descriptor = 5'(desc);
      w.byte_count = 4'(cnt);
      w.data_word = data;
      return w;
   endfunction

   function automatic logic [63:0] rand_data();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_desc();
      if (open_descs.size() > 0 && $urandom_range(0, 9) != 0)
         return open_descs[$urandom_range(0, open_descs.size() - 1)];
      return $urandom_range(0, 31);
   endfunction

   // Mostly meaningful traffic: reads and writes on live descriptors, plus
   // lifecycle churn and some noise.
   function automatic nfdt_pkg::nfdt_req_type random_req();
      int sel;
      logic [2:0] kind;
      sel = $urandom_range(0, 99);
      if (sel < 8) kind = nfdt_pkg::REQ_CREATE;
      else if (sel < 18) kind = nfdt_pkg::REQ_OPEN;
      else if (sel < 23) kind = nfdt_pkg::REQ_DUP;
      else if (sel < 29) kind = nfdt_pkg::REQ_CLOSE;
      else if (sel < 62) kind = nfdt_pkg::REQ_WRITE;
      else if (sel < 97) kind = nfdt_pkg::REQ_READ;
      else kind = 3'($urandom_range(6, 7));
      return make_req(kind, $urandom_range(0, 15), $urandom_range(0, 3), pick_desc(),
                      $urandom_range(0, 15), rand_data());
   endfunction

   initial begin
      nfdt_pkg::nfdt_req_type w;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part.
      send_word(make_req(nfdt_pkg::REQ_OPEN, 3, 0, 0, 0, 0));          // no FIFO there
      send_word(make_req(nfdt_pkg::REQ_CREATE, 0, nfdt_pkg::MODE_RW, 0, 0, 0));
      send_word(make_req(nfdt_pkg::REQ_CREATE, 0, 1, 0, 0, 0));        // slot in use
      send_word(make_req(nfdt_pkg::REQ_CREATE, 15, 1, 0, 0, 0));       // read-only mask
      send_word(make_req(nfdt_pkg::REQ_CREATE, 7, 0, 0, 0, 0));        // empty mask
      send_word(make_req(nfdt_pkg::REQ_OPEN, 0, 0, 0, 0, 0));          // mode 0 is read-write
      send_word(make_req(nfdt_pkg::REQ_OPEN, 15, 2, 0, 0, 0));         // right not in mask
      send_word(make_req(nfdt_pkg::REQ_OPEN, 15, 1, 0, 0, 0));
      send_word(make_req(nfdt_pkg::REQ_OPEN, 7, 1, 0, 0, 0));          // empty mask refuses
      send_word(make_req(nfdt_pkg::REQ_READ, 0, 0, 0, 8, 0));          // empty ring
      send_word(make_req(nfdt_pkg::REQ_WRITE, 0, 0, 0, 15, 64'hFFFF_FFFF_FFFF_FFFF));
      send_word(make_req(nfdt_pkg::REQ_WRITE, 0, 0, 0, 3, 64'h0123_4567_89AB_CDEF));
      send_word(make_req(nfdt_pkg::REQ_WRITE, 0, 0, 1, 4, 64'h55));    // no write right
      send_word(make_req(nfdt_pkg::REQ_READ, 0, 0, 0, 0, 0));
      send_word(make_req(nfdt_pkg::REQ_READ, 0, 0, 0, 15, 0));         // count saturates
      send_word(make_req(nfdt_pkg::REQ_DUP, 0, 0, 0, 0, 0));
      send_word(make_req(nfdt_pkg::REQ_DUP, 0, 0, 31, 0, 0));          // not open
      send_word(make_req(nfdt_pkg::REQ_READ, 0, 0, 2, 8, 0));
      send_word(make_req(nfdt_pkg::REQ_CLOSE, 0, 0, 30, 0, 0));        // not open
      send_word(make_req(nfdt_pkg::REQ_CLOSE, 0, 0, 1, 0, 0));         // last ref of slot 15
      send_word(make_req(6, 0, 0, 0, 0, 64'hAA));
      send_word(make_req(7, 15, 3, 31, 8, 64'h5500));
      for (int i = 0; i < 3; i++) open_descs.push_back(i);

      // Pause until all responses have come back.
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // Fill the descriptor table and one ring to the brim.
      for (int i = 0; i < 32; i++) send_word(make_req(nfdt_pkg::REQ_DUP, 0, 0, 0, 0, 0));
      for (int i = 0; i < 130; i++)
         send_word(make_req(nfdt_pkg::REQ_WRITE, 0, 0, 0, 8, rand_data()));
      for (int i = 0; i < 130; i++) send_word(make_req(nfdt_pkg::REQ_READ, 0, 0, 2, 8, 0));
      for (int i = 3; i < 32; i++) send_word(make_req(nfdt_pkg::REQ_CLOSE, 0, 0, i, 0, 0));

      // Long receiver hold-off while requests keep coming.
      hold_cycles = 200;
      for (int i = 0; i < 20; i++)
         send_word(make_req(nfdt_pkg::REQ_WRITE, 0, 0, 0, $urandom_range(0, 8), rand_data()));

      for (int n = 0; n < 1100; n++) begin
         w = random_req();
         send_word(w);
         if (n % 50 == 0) begin
            // Track opened descriptors loosely; stale ones only give errors.
            open_descs.delete();
            for (int i = 0; i < 6; i++) open_descs.push_back(i);
         end
      end

      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
